// ----- rtl/core/mouse_report_to_event_core_macros.svh -----
// Assertion helpers for the checker file.
`ifndef MOUSE_REPORT_TO_EVENT_CORE_MACROS_SVH
`define MOUSE_REPORT_TO_EVENT_CORE_MACROS_SVH

// Property checked on every rising edge outside reset.
`define MRE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define MRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mre_pkg.sv -----
package mre_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_REPORT_MODE   = 2'd2;

   localparam logic MODE_PS2 = 1'b0;
   localparam logic MODE_USB = 1'b1;

   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_MOVE        = 3'd1;
   localparam logic [2:0] EV_LEFT_DOWN   = 3'd2;
   localparam logic [2:0] EV_LEFT_UP     = 3'd3;
   localparam logic [2:0] EV_RIGHT_DOWN  = 3'd4;
   localparam logic [2:0] EV_RIGHT_UP    = 3'd5;
   localparam logic [2:0] EV_MIDDLE_DOWN = 3'd6;
   localparam logic [2:0] EV_MIDDLE_UP   = 3'd7;

   localparam logic [10:0] WIDTH_RESET  = 11'd320;
   localparam logic [10:0] HEIGHT_RESET = 11'd200;
   localparam logic [9:0]  HOME_X       = 10'd160;
   localparam logic [9:0]  HOME_Y       = 10'd100;

   typedef struct packed {
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic [2:0]         button_bits;
   } mre_req_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [9:0] pointer_x;
      logic [9:0] pointer_y;
   } mre_rsp_type;

   typedef struct packed {
      logic [10:0] screen_width;
      logic [10:0] screen_height;
      logic        report_mode;
   } mre_cfg_type;

   typedef struct packed {
      logic [9:0] pos_x;
      logic [9:0] pos_y;
      logic [2:0] buttons;
   } mre_state_type;

endpackage

// ----- rtl/core/mre_event_calc.sv -----
module mre_event_calc (
   input  mre_pkg::mre_cfg_type   cfg,
   input  mre_pkg::mre_state_type state_cur,
   input  mre_pkg::mre_req_type   req,
   output mre_pkg::mre_state_type state_next,
   output logic [2:0]             event_kind
);
   import mre_pkg::*;

   localparam logic signed [15:0] PS2_MAX = 16'sd127;

   function automatic logic signed [16:0] clamp_delta(input logic signed [15:0] d);
      logic signed [16:0] r;
      if (d > PS2_MAX) r = 17'sd127;
      else if (d < -PS2_MAX) r = -17'sd127;
      else r = $signed({d[15], d});
      return r;
   endfunction

   // halve, rounding toward zero
   function automatic logic signed [16:0] half_delta(input logic signed [15:0] d);
      logic signed [16:0] t;
      t = $signed({d[15], d}) + $signed({16'b0, d[15]});
      return t >>> 1;
   endfunction

   function automatic logic [9:0] clamp_pos(input logic signed [17:0] p,
                                            input logic [10:0] size);
      logic [10:0] m;
      logic [9:0]  hi;
      logic [9:0]  r;
      m = size - 11'd1;
      if (size > 11'd1024) hi = 10'd1023;
      else if (size == 11'd0) hi = 10'd0;
      else hi = m[9:0];
      if (p < 0) r = 10'd0;
      else if (p > $signed({8'b0, hi})) r = hi;
      else r = p[9:0];
      return r;
   endfunction

   logic [2:0]         diff;
   logic               hit;
   logic [2:0]         btn_kind;
   logic [2:0]         btn_next;
   logic               moved;
   logic               apply;
   logic signed [16:0] step_x;
   logic signed [16:0] step_y;
   logic signed [17:0] sum_x;
   logic signed [17:0] sum_y;

   assign diff  = req.button_bits ^ state_cur.buttons;
   assign hit   = |diff;
   assign moved = (req.delta_x != 16'sd0) || (req.delta_y != 16'sd0);

   // first changed button wins: left, right, middle
   always_comb begin
      btn_next = state_cur.buttons;
      btn_kind = EV_NONE;
      if (diff[0]) begin
         btn_next[0] = req.button_bits[0];
         btn_kind    = req.button_bits[0] ? EV_LEFT_DOWN : EV_LEFT_UP;
      end else if (diff[1]) begin
         btn_next[1] = req.button_bits[1];
         btn_kind    = req.button_bits[1] ? EV_RIGHT_DOWN : EV_RIGHT_UP;
      end else if (diff[2]) begin
         btn_next[2] = req.button_bits[2];
         btn_kind    = req.button_bits[2] ? EV_MIDDLE_DOWN : EV_MIDDLE_UP;
      end
   end

   always_comb begin
      if (cfg.report_mode == MODE_PS2) begin
         step_x = clamp_delta(req.delta_x);
         step_y = -clamp_delta(req.delta_y);
      end else begin
         step_x = half_delta(req.delta_x);
         step_y = half_delta(req.delta_y);
      end
   end

   assign sum_x = $signed({8'b0, state_cur.pos_x}) + $signed({step_x[16], step_x});
   assign sum_y = $signed({8'b0, state_cur.pos_y}) + $signed({step_y[16], step_y});

   // USB drops motion when a button event goes out
   assign apply = moved && ((cfg.report_mode == MODE_PS2) || !hit);

   always_comb begin
      state_next.buttons = btn_next;
      state_next.pos_x   = apply ? clamp_pos(sum_x, cfg.screen_width) : state_cur.pos_x;
      state_next.pos_y   = apply ? clamp_pos(sum_y, cfg.screen_height) : state_cur.pos_y;
      if (hit) event_kind = btn_kind;
      else if (moved) event_kind = EV_MOVE;
      else event_kind = EV_NONE;
   end

endmodule

// ----- rtl/core/mouse_report_to_event_core.sv -----
// Mouse report to pointer event converter.
// Request channel (req_valid/req_ready/req_data): one mouse report per
// request, signed X/Y deltas and three button bits.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one event per
// request, in order, with the pointer position after that report.
// Configuration: APB-style port; screen width at 0x0, screen height at 0x4,
// report mode at 0x8 (0 PS/2, 1 USB). Write only while no request is in flight.
// A taken request moves from the input register to the response register,
// which drives rsp_valid. Throughput: one request per cycle unless stalled;
// pointer and button state update as the response register is loaded.
// Reset: registers return to 320 x 200, PS/2 mode, pointer at (160,100),
// all buttons released, both stages empty.
// Stall: while rsp_ready is low the response holds; one more request can
// wait in the input register, after which req_ready drops.
module mouse_report_to_event_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mre_pkg::mre_req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mre_pkg::mre_rsp_type                  rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [mre_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [mre_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [mre_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import mre_pkg::*;

   mre_cfg_type   cfg_ff;
   mre_cfg_type   cfg_in;
   mre_state_type state_ff;
   mre_state_type state_in;
   mre_state_type state_calc;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   mre_req_type   s1_req_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   mre_rsp_type   rsp_data_ff;
   mre_rsp_type   rsp_data_in;
   logic [2:0]    kind_calc;
   logic          req_take;
   logic          out_free;
   logic          s1_adv;
   logic          csr_we;
   logic [1:0]    csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_we  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = pwdata[10:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = pwdata[10:0];
            REG_REPORT_MODE:   cfg_in.report_mode   = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SCREEN_WIDTH:  prdata = {21'b0, cfg_ff.screen_width};
         REG_SCREEN_HEIGHT: prdata = {21'b0, cfg_ff.screen_height};
         REG_REPORT_MODE:   prdata = {31'b0, cfg_ff.report_mode};
         default:           prdata = '0;
      endcase
   end

   // two-stage flow: input register, then response register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   mre_event_calc u_calc (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .req        (s1_req_ff),
      .state_next (state_calc),
      .event_kind (kind_calc)
   );

   assign state_in = s1_adv ? state_calc : state_ff;

   always_comb begin
      rsp_data_in.event_kind = kind_calc;
      rsp_data_in.pointer_x  = state_calc.pos_x;
      rsp_data_in.pointer_y  = state_calc.pos_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= WIDTH_RESET;
         cfg_ff.screen_height <= HEIGHT_RESET;
         cfg_ff.report_mode   <= MODE_PS2;
         state_ff.pos_x       <= HOME_X;
         state_ff.pos_y       <= HOME_Y;
         state_ff.buttons     <= 3'b000;
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/mre_checker.sv -----
`include "mouse_report_to_event_core_macros.svh"

module mre_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mre_pkg::mre_rsp_type rsp_data
);
   import mre_pkg::*;

   // an empty response side never stalls requests
   `MRE_ASSERT(a_no_bubble_stall, clock, reset, (!rsp_valid |-> req_ready), "req_ready low with empty response")
   // every request shows up as a response, through the input and response registers
   `MRE_ASSERT(a_req_to_rsp, clock, reset, (req_valid && req_ready |-> ##2 rsp_valid), "request lost in pipe")
   // hold a stalled response
   `MRE_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)), "stalled response changed")
   // no response is valid after reset
   `MRE_ASSERT_ALWAYS(a_reset_empty, clock, (reset |=> !rsp_valid), "response valid after reset")

endmodule

bind mouse_report_to_event_core mre_checker u_mre_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
